>>> rtl/assert_macros.svh
// Assertion macros used by the trie RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while in reset.
`define BTRIE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("btrie assertion failed");

// Next-cycle implication, masked while in reset.
`define BTRIE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("btrie assertion failed");

`endif

>>> rtl/btrie_pkg.sv
// Package: constants, item types and memory request types of the byte trie.
`timescale 1ns / 1ps
package btrie_pkg;

  localparam int NODES     = 1024;
  localparam int ALPHABET  = 256;
  localparam int NODE_W    = $clog2(NODES);
  localparam int SYM_W     = 8;
  localparam int SYM_IDX_W = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int ROW_W     = NODE_W + SYM_IDX_W;
  localparam int EDGE_DEPTH = NODES * (1 << SYM_IDX_W);
  localparam int NODE_OUT_W = 10;

  typedef enum logic [1:0] {
    KIND_INS_BYTE = 2'd0,
    KIND_INS_END  = 2'd1,
    KIND_LKP_BYTE = 2'd2,
    KIND_LKP_END  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EDGE,
    ST_NODE
  } state_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [SYM_W-1:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic                  hit;
    logic [NODE_OUT_W-1:0] node;
    logic                  word_end;
    logic                  full_res;
  } out_item_t;

  // Per-node entry: word-end mark and the edge-table row that created the node.
  typedef struct packed {
    logic             end_mark;
    logic [ROW_W-1:0] parent;
  } node_ent_t;

  typedef struct packed {
    logic              we;
    logic [ROW_W-1:0]  waddr;
    logic [NODE_W-1:0] wdata;
    logic              re;
    logic [ROW_W-1:0]  raddr;
  } edge_req_t;

  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] waddr;
    node_ent_t         wdata;
    logic              re;
    logic [NODE_W-1:0] raddr;
  } node_req_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_push_t;

endpackage

>>> rtl/btrie_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module btrie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/btrie_ctrl.sv
// Sequencer: cursor, allocation counter and edge/node memory read-modify-write.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module btrie_ctrl import btrie_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  in_item_t          in_data,
  output logic              in_stall,
  input  logic              slot_free,
  output res_push_t         push,
  output edge_req_t         edge_req,
  input  logic [NODE_W-1:0] edge_rdata,
  output node_req_t         node_req,
  input  node_ent_t         node_rdata
);

  state_t            state_r, state_nxt;
  logic [NODE_W-1:0] cursor_r, cursor_nxt;
  logic [ROW_W-1:0]  cursor_ix_r, cursor_ix_nxt;
  logic              cursor_end_r, cursor_end_nxt;
  logic [NODE_W-1:0] next_free_r, next_free_nxt;
  logic              root_mark_r, root_mark_nxt;
  logic [ROW_W-1:0]  ix_r, ix_nxt;
  logic              is_ins_r, is_ins_nxt;

  logic              accept;
  logic              sym_ok;
  logic [ROW_W-1:0]  row_in;
  logic              edge_ok;
  logic              table_full;
  logic [NODE_W-1:0] alloc_node;

  assign sym_ok     = ({1'b0, in_data.symbol} < (SYM_W + 1)'(ALPHABET));
  assign row_in     = {cursor_r, in_data.symbol[SYM_IDX_W-1:0]};
  assign table_full = (next_free_r == NODE_W'(NODES - 1));
  assign alloc_node = next_free_r + NODE_W'(1);
  // A stale entry either points past the allocated nodes or at a node made elsewhere.
  assign edge_ok    = (edge_rdata != '0) && (edge_rdata <= next_free_r)
                      && (node_rdata.parent == ix_r);

  assign in_stall = !((state_r == ST_IDLE) && slot_free);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cursor_r     <= '0;
      cursor_end_r <= 1'b0;
      next_free_r  <= '0;
      root_mark_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cursor_r     <= cursor_nxt;
      cursor_end_r <= cursor_end_nxt;
      next_free_r  <= next_free_nxt;
      root_mark_r  <= root_mark_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cursor_ix_r <= cursor_ix_nxt;
    ix_r        <= ix_nxt;
    is_ins_r    <= is_ins_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cursor_nxt     = cursor_r;
    cursor_ix_nxt  = cursor_ix_r;
    cursor_end_nxt = cursor_end_r;
    next_free_nxt  = next_free_r;
    root_mark_nxt  = root_mark_r;
    ix_nxt         = ix_r;
    is_ins_nxt     = is_ins_r;
    push           = '0;
    edge_req       = '0;
    node_req       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind_t'(in_data.kind)) inside
            KIND_INS_END: begin
              push.valid = 1'b1;
              if (cursor_r == '0) begin
                root_mark_nxt      = 1'b1;
                push.item.word_end = 1'b1;
              end else begin
                node_req.we             = 1'b1;
                node_req.waddr          = cursor_r;
                node_req.wdata.end_mark = 1'b1;
                node_req.wdata.parent   = cursor_ix_r;
                push.item.word_end      = root_mark_r;
              end
              cursor_nxt     = '0;
              cursor_end_nxt = push.item.word_end;
            end
            KIND_LKP_END: begin
              push.valid         = 1'b1;
              push.item.word_end = root_mark_r;
              cursor_nxt         = '0;
              cursor_end_nxt     = root_mark_r;
            end
            KIND_INS_BYTE, KIND_LKP_BYTE: begin
              if (!sym_ok) begin
                // No edge can exist: stay put.
                push.valid         = 1'b1;
                push.item.node     = NODE_OUT_W'(cursor_r);
                push.item.word_end = cursor_end_r;
              end else begin
                edge_req.re    = 1'b1;
                edge_req.raddr = row_in;
                ix_nxt         = row_in;
                is_ins_nxt     = (kind_t'(in_data.kind) == KIND_INS_BYTE);
                state_nxt      = ST_EDGE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_EDGE: begin
        node_req.re    = 1'b1;
        node_req.raddr = edge_rdata;
        state_nxt      = ST_NODE;
      end
      ST_NODE: begin
        // Hold memory read data until the output slot frees up.
        if (slot_free) begin
          push.valid = 1'b1;
          state_nxt  = ST_IDLE;
          if (edge_ok) begin
            push.item.hit  = 1'b1;
            cursor_nxt     = edge_rdata;
            cursor_ix_nxt  = ix_r;
            cursor_end_nxt = node_rdata.end_mark;
          end else if (is_ins_r && !table_full) begin
            next_free_nxt           = alloc_node;
            edge_req.we             = 1'b1;
            edge_req.waddr          = ix_r;
            edge_req.wdata          = alloc_node;
            node_req.we             = 1'b1;
            node_req.waddr          = alloc_node;
            node_req.wdata.end_mark = 1'b0;
            node_req.wdata.parent   = ix_r;
            cursor_nxt              = alloc_node;
            cursor_ix_nxt           = ix_r;
            cursor_end_nxt          = 1'b0;
          end else if (is_ins_r) begin
            push.item.full_res = 1'b1;
          end
          push.item.node     = NODE_OUT_W'(cursor_nxt);
          push.item.word_end = cursor_end_nxt;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `BTRIE_ASSERT_NXT(a_next_free_mono, clk, rst_n, 1'b1, next_free_r >= $past(next_free_r))
  `BTRIE_ASSERT_IMP(a_cursor_alloc, clk, rst_n, 1'b1, cursor_r <= next_free_r)
  `BTRIE_ASSERT_IMP(a_push_slot, clk, rst_n, push.valid, slot_free)
  `BTRIE_ASSERT_IMP(a_hit_not_full, clk, rst_n, push.valid, !(push.item.hit && push.item.full_res))

endmodule

>>> rtl/byte_trie_insert_lookup_core.sv
// Top level of the byte trie: sequencer, edge and node memories, result register.
//
// Input channel (in_valid/in_stall/in_data) carries one command per beat:
// insert byte, end inserted word, lookup byte or end lookup word. Every
// command yields exactly one result beat on out_valid/out_stall/out_data:
// hit flag, cursor node after the command, its word-end mark, and the
// table-full flag for an insert that found no free node.
// End commands and bytes outside the alphabet produce their result in the
// cycle after acceptance. Insert and lookup bytes read the edge table at
// {cursor, byte}, then the node memory at the child for its parent row and
// word-end mark, then decide and write back. The cursor dependency between
// bytes holds off the next command until that write-back is done.
// Reset (rst_n low, synchronous) returns the cursor to the root and empties
// the trie at once: an edge entry counts only if its child lies within the
// allocated nodes and names that entry as its parent, so no clearing pass
// runs. A result waits in the output register while out_stall is high; the
// next command is taken only once that register is free or being emptied.
`timescale 1ns / 1ps
module byte_trie_insert_lookup_core import btrie_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;
  logic              slot_free;
  res_push_t         push;
  edge_req_t         edge_req;
  node_req_t         node_req;
  logic [NODE_W-1:0] edge_rdata;
  node_ent_t         node_rdata;

  assign slot_free = !out_valid_r || !out_stall;

  btrie_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_stall   (in_stall),
    .slot_free  (slot_free),
    .push       (push),
    .edge_req   (edge_req),
    .edge_rdata (edge_rdata),
    .node_req   (node_req),
    .node_rdata (node_rdata)
  );

  btrie_ram #(
    .WIDTH (NODE_W),
    .DEPTH (EDGE_DEPTH)
  ) u_edge_ram (
    .clk   (clk),
    .we    (edge_req.we),
    .waddr (edge_req.waddr),
    .wdata (edge_req.wdata),
    .re    (edge_req.re),
    .raddr (edge_req.raddr),
    .rdata (edge_rdata)
  );

  btrie_ram #(
    .WIDTH ($bits(node_ent_t)),
    .DEPTH (NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_req.we),
    .waddr (node_req.waddr),
    .wdata (node_req.wdata),
    .re    (node_req.re),
    .raddr (node_req.raddr),
    .rdata (node_rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (push.valid) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = push.item;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> dv/byte_trie_insert_lookup_core_tb.sv
// Testbench for the byte trie core: directed and random command beats checked by a trie predictor.
`timescale 1ns / 1ps

class trie_scoreboard;
  int          child_of [int];
  bit          end_mark [btrie_pkg::NODES];
  int unsigned cursor;
  int unsigned next_free;
  int unsigned n_results;
  int unsigned errors;
  btrie_pkg::out_item_t due [$];

  function new();
    cursor    = 0;
    next_free = 0;
    n_results = 0;
    errors    = 0;
  endfunction

  // Advance the trie by one command and queue the result it should produce.
  function void note_input(btrie_pkg::in_item_t cmd);
    btrie_pkg::out_item_t want;
    int key;
    bit in_alpha;
    bit hit;
    bit full;
    hit      = 1'b0;
    full     = 1'b0;
    in_alpha = int'(cmd.symbol) < btrie_pkg::ALPHABET;
    key      = int'(cursor) * btrie_pkg::ALPHABET + int'(cmd.symbol);
    case (btrie_pkg::kind_t'(cmd.kind))
      btrie_pkg::KIND_INS_BYTE: begin
        if (in_alpha) begin
          if (child_of.exists(key)) begin
            hit    = 1'b1;
            cursor = child_of[key];
          end else if (next_free + 1 < btrie_pkg::NODES) begin
            next_free     = next_free + 1;
            child_of[key] = next_free;
            cursor        = next_free;
          end else begin
            full = 1'b1;
          end
        end
      end
      btrie_pkg::KIND_INS_END: begin
        end_mark[cursor] = 1'b1;
        cursor           = 0;
      end
      btrie_pkg::KIND_LKP_BYTE: begin
        if (in_alpha && child_of.exists(key)) begin
          hit    = 1'b1;
          cursor = child_of[key];
        end
      end
      default: cursor = 0;
    endcase
    want.hit      = hit;
    want.node     = btrie_pkg::NODE_OUT_W'(cursor);
    want.word_end = end_mark[cursor];
    want.full_res = full;
    due.push_back(want);
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_result(btrie_pkg::out_item_t got);
    btrie_pkg::out_item_t want;
    n_results++;
    if (due.size() == 0) begin
      report($sformatf("result %0d arrived with nothing expected", n_results));
      return;
    end
    want = due.pop_front();
    if (got.hit !== want.hit)
      report($sformatf("result %0d hit got %b want %b", n_results, got.hit, want.hit));
    if (got.node !== want.node)
      report($sformatf("result %0d node got %0d want %0d", n_results, got.node, want.node));
    if (got.word_end !== want.word_end)
      report($sformatf("result %0d word_end got %b want %b", n_results, got.word_end,
                       want.word_end));
    if (got.full_res !== want.full_res)
      report($sformatf("result %0d full_res got %b want %b", n_results, got.full_res,
                       want.full_res));
  endtask
endclass

module byte_trie_insert_lookup_core_tb;
  import btrie_pkg::*;

  localparam int IDLE_LIMIT  = 1000;
  localparam int LONG_HOLD   = 80;
  localparam int TAIL_CYCLES = 8;
  localparam int MAX_WORD    = 16;

  typedef struct packed {
    bit [8*MAX_WORD-1:0] bytes;
    bit [4:0]            len;
  } word_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      hold_req  = 1'b0;

  trie_scoreboard sb = new();
  word_t          words [$];
  bit             tx_calm = 1'b0;
  bit             rx_calm = 1'b0;
  int unsigned    rx_wait = 0;
  int unsigned    rx_hold = 0;
  int unsigned    sent    = 0;

  always #10 clk = ~clk;

  byte_trie_insert_lookup_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Result side: check each beat, then stall for a drawn number of cycles.
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_req) begin
        hold_req <= 1'b0;
        rx_hold = LONG_HOLD;
      end
      if (out_valid && !out_stall) begin
        sb.check_result(out_data);
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        rx_wait = rx_calm ? 0 : $urandom_range(0, 11);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      if (rx_hold > 0) rx_hold--;
      out_stall <= (rx_wait > 0) || (rx_hold > 0);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("FAIL byte_trie_insert_lookup_core");
    $finish;
  end

  // Mostly a few shared bytes so words overlap; sometimes any byte, and always when wide.
  function automatic logic [7:0] pick_sym(bit wide);
    if (wide || $urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h5A;
      default: return 8'hA5;
    endcase
  endfunction

  task automatic send(kind_t kind, logic [7:0] symbol);
    in_item_t    cmd;
    int unsigned gap;
    cmd.kind   = kind;
    cmd.symbol = symbol;
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(cmd);
    sent++;
  endtask

  // Drop valid and hold until every expected beat has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.due.size() != 0);
  endtask

  task automatic insert_word(int unsigned len, bit wide);
    word_t w;
    w = '0;
    w.len = 5'(len);
    for (int i = 0; i < len; i++) begin
      w.bytes[8*i +: 8] = pick_sym(wide);
      send(KIND_INS_BYTE, w.bytes[8*i +: 8]);
    end
    // Now and then abandon the word without marking it.
    if ($urandom_range(0, 7) == 0) begin
      send(KIND_LKP_END, pick_sym(1'b1));
    end else begin
      send(KIND_INS_END, pick_sym(1'b1));
      words.push_back(w);
    end
  endtask

  task automatic lookup_word();
    word_t       w;
    int unsigned len;
    if (words.size() == 0) begin
      w.len = 5'($urandom_range(1, 6));
      for (int i = 0; i < MAX_WORD; i++) w.bytes[8*i +: 8] = pick_sym(1'b0);
    end else begin
      w = words[$urandom_range(0, words.size() - 1)];
    end
    len = w.len;
    if (len > 1 && $urandom_range(0, 3) == 0) len = $urandom_range(1, len - 1);
    if ($urandom_range(0, 3) == 0)
      w.bytes[8*$urandom_range(0, len - 1) +: 8] = pick_sym(1'b0);
    for (int i = 0; i < len; i++) send(KIND_LKP_BYTE, w.bytes[8*i +: 8]);
    if ($urandom_range(0, 7) == 0) send(KIND_INS_END, pick_sym(1'b1));
    else send(KIND_LKP_END, pick_sym(1'b1));
  endtask

  task automatic random_phrase();
    case ($urandom_range(0, 9)) inside
      0, 1, 2: insert_word($urandom_range(1, 6), 1'b0);
      3:       insert_word($urandom_range(1, MAX_WORD), 1'b1);
      4, 5, 6: lookup_word();
      7: begin
        repeat ($urandom_range(1, 4))
          send(kind_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
      8: begin
        repeat ($urandom_range(1, 6)) send(KIND_LKP_BYTE, pick_sym(1'b0));
        send(KIND_LKP_END, pick_sym(1'b1));
      end
      default: insert_word($urandom_range(1, 4), 1'b0);
    endcase
  endtask

  initial begin
    bit held;
    bit paused;
    held   = 1'b0;
    paused = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Empty trie: lookup misses, then mark the root with an empty word.
    send(KIND_LKP_BYTE, 8'h00);
    send(KIND_LKP_END,  8'hFF);
    send(KIND_INS_END,  8'h00);
    send(KIND_LKP_END,  8'h00);
    send(KIND_INS_BYTE, 8'h00);
    send(KIND_INS_BYTE, 8'hFF);
    send(KIND_INS_END,  8'hFF);
    // Shared prefix follows the existing edge.
    send(KIND_INS_BYTE, 8'h00);
    send(KIND_INS_BYTE, 8'h80);
    send(KIND_INS_END,  8'h00);
    send(KIND_LKP_BYTE, 8'h00);
    send(KIND_LKP_BYTE, 8'hFF);
    send(KIND_LKP_BYTE, 8'h55);
    send(KIND_LKP_END,  8'h00);
    send(KIND_LKP_BYTE, 8'hFF);
    send(KIND_LKP_BYTE, 8'hAA);
    send(KIND_LKP_END,  8'hAA);
    // Abandon an insert with a lookup end, then retake the edge.
    send(KIND_INS_BYTE, 8'h55);
    send(KIND_INS_BYTE, 8'hAA);
    send(KIND_LKP_END,  8'h55);
    send(KIND_INS_BYTE, 8'h55);
    send(KIND_INS_END,  8'h55);
    drain();

    while (sent < 700) begin
      if (sent >= 300 && !held) begin
        hold_req <= 1'b1;
        held = 1'b1;
      end
      if (sent >= 480 && !paused) begin
        drain();
        paused = 1'b1;
      end
      random_phrase();
    end

    // Use up the node pool, then keep inserting into a full table.
    while (sb.next_free < NODES - 1) insert_word(MAX_WORD, 1'b1);
    repeat (6) send(KIND_INS_BYTE, 8'($urandom_range(0, 255)));
    send(KIND_INS_END, 8'h00);
    repeat (30) random_phrase();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("PASS byte_trie_insert_lookup_core");
    else $display("FAIL byte_trie_insert_lookup_core");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+rtl
rtl/btrie_pkg.sv
rtl/btrie_ram.sv
rtl/btrie_ctrl.sv
rtl/byte_trie_insert_lookup_core.sv
dv/byte_trie_insert_lookup_core_tb.sv
